@@ rtl/core/dq_pkg.sv @@
// Double-ended queue package: request and response payloads, command and
// status codes, and the control word handed to every storage cell.
// No dependencies.
package dq_pkg;

    localparam int WORD_W = 32;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;
    localparam logic [2:0] CMD_PEEK       = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [2:0]        command;
        logic [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] front_value;
        logic [WORD_W-1:0] back_value;
        logic [6:0]        count;
        logic              empty_res;
        logic              full_res;
        logic [1:0]        status;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_HOLD    = 2'd0,
        OP_SHIFT_R = 2'd1,
        OP_SHIFT_L = 2'd2,
        OP_LOAD    = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] value;
    } cell_ctrl_t;

endpackage

@@ rtl/core/dq_cell.sv @@
// Double-ended queue storage cell: one word, shifted to or from its neighbours
// or loaded in place, with a tap that shows the word when it is the back one.
// Depends on dq_pkg.
module dq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                      clk,
    input  dq_pkg::cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]          count,
    input  logic [dq_pkg::WORD_W-1:0] left_word,
    input  logic [dq_pkg::WORD_W-1:0] right_word,
    output logic [dq_pkg::WORD_W-1:0] word,
    output logic [dq_pkg::WORD_W-1:0] tap
);
    import dq_pkg::*;

    localparam logic [CNT_W-1:0] SLOT_POS = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(INDEX + 1);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        case (ctrl.op)
            OP_SHIFT_R: word_next = left_word;
            OP_SHIFT_L: word_next = right_word;
            OP_LOAD:    word_next = (count == SLOT_POS) ? ctrl.value : word_reg;
            default:    word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign tap  = (count == LAST_POS) ? word_reg : '0;

endmodule

@@ rtl/core/double_ended_queue_top.sv @@
// Double-ended queue top level: cell row, request decode, back-word reduction
// tree and response register.
// Depends on dq_pkg and dq_cell.
//
// Bounded deque of CAPACITY 32-bit words held in a row of cells with the front
// word always in cell 0. The edge that accepts a request updates the cell row
// and count, the S_REDUCE state then registers the group ORs that pick out the
// back word, and the S_FINAL state loads the response. One request is in flight
// at a time; the next is taken as soon as the response is registered, even
// while that response still waits on rsp_stall, and it holds in its last step
// until the response register is free. Pops on an empty queue report underflow,
// pushes on a full queue report overflow; both leave the contents unchanged.
module double_ended_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_stall,
    input  dq_pkg::req_t req,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output dq_pkg::rsp_t rsp
);
    import dq_pkg::*;

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int GROUP   = 8;
    localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REDUCE = 3'b010,
        S_FINAL  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        status_reg, status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_load;

    logic              accept;
    cell_ctrl_t        ctrl;

    logic [WORD_W-1:0] words [CAPACITY];
    logic [WORD_W-1:0] taps  [NGROUPS*GROUP];
    logic [WORD_W-1:0] group_reg  [NGROUPS];
    logic [WORD_W-1:0] group_next [NGROUPS];
    logic [WORD_W-1:0] back_word;
    logic [CNT_W+6:0]  count_ext;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            dq_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .left_word  ((gi == 0) ? ctrl.value : words[(gi == 0) ? 0 : gi - 1]),
                .right_word (words[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .word       (words[gi]),
                .tap        (taps[gi])
            );
        end
        for (gi = CAPACITY; gi < NGROUPS * GROUP; gi++)
        begin : g_pad
            assign taps[gi] = '0;
        end
    endgenerate

    always_comb
    begin
        ctrl.op     = OP_HOLD;
        ctrl.value  = req.value;
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            status_next = ST_OK;
            unique case (req.command)
                CMD_PUSH_FRONT:
                begin
                    if (count_reg == FULL_COUNT)
                        status_next = ST_OVERFLOW;
                    else
                    begin
                        ctrl.op    = OP_SHIFT_R;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (count_reg == FULL_COUNT)
                        status_next = ST_OVERFLOW;
                    else
                    begin
                        ctrl.op    = OP_LOAD;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (count_reg == '0)
                        status_next = ST_UNDERFLOW;
                    else
                    begin
                        ctrl.op    = OP_SHIFT_L;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_POP_BACK:
                begin
                    if (count_reg == '0)
                        status_next = ST_UNDERFLOW;
                    else
                        count_next = count_reg - CNT_W'(1);
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
                group_next[g] = group_next[g] | taps[g*GROUP + k];
        end
    end

    always_comb
    begin
        back_word = '0;
        for (int g = 0; g < NGROUPS; g++)
            back_word = back_word | group_reg[g];
    end

    assign count_ext = {7'b0, count_reg};

    always_comb
    begin
        state_next     = state_reg;
        rsp_load       = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_next.front_value = (count_reg != '0) ? words[0] : '0;
        rsp_next.back_value  = back_word;
        rsp_next.count       = count_ext[6:0];
        rsp_next.empty_res   = (count_reg == '0);
        rsp_next.full_res    = (count_reg == FULL_COUNT);
        rsp_next.status      = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_REDUCE)
            group_reg <= group_next;
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_REDUCE)
        else $error("accepted request did not start the reduction");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("element count beyond capacity");

    a_final_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL) && !(rsp_valid_reg && rsp_stall)
        |=> rsp_valid_reg && (state_reg == S_IDLE))
        else $error("finished request not loaded into response register");

endmodule

@@ bench/tb_double_ended_queue_top.sv @@
// Self-checking bench for double_ended_queue_top: directed and biased random requests with
// a scoreboard class that tracks the ring contents and checks every response.
// Depends on dq_pkg and the double_ended_queue_top RTL.
`timescale 1ns / 1ps

module tb_double_ended_queue_top;
    import dq_pkg::*;

    localparam int DEPTH = 64;
    localparam int RANDOM_REQUESTS = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef enum int {FILL_BIAS, DRAIN_BIAS, BALANCED} mix_t;

    class dq_scoreboard;
        logic [WORD_W-1:0] ring [DEPTH];
        int unsigned head;
        int unsigned fill;
        rsp_t expected_q[$];
        int unsigned failures;

        function new();
            head = 0;
            fill = 0;
            failures = 0;
        endfunction

        function void note_request(req_t item);
            rsp_t exp;
            logic [1:0] st;
            st = ST_OK;
            case (item.command)
                CMD_PUSH_FRONT:
                    if (fill >= DEPTH) st = ST_OVERFLOW;
                    else
                    begin
                        head = (head + DEPTH - 1) % DEPTH;
                        ring[head] = item.value;
                        fill++;
                    end
                CMD_PUSH_BACK:
                    if (fill >= DEPTH) st = ST_OVERFLOW;
                    else
                    begin
                        ring[(head + fill) % DEPTH] = item.value;
                        fill++;
                    end
                CMD_POP_FRONT:
                    if (fill == 0) st = ST_UNDERFLOW;
                    else
                    begin
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                CMD_POP_BACK:
                    if (fill == 0) st = ST_UNDERFLOW;
                    else fill--;
                CMD_CLEAR:
                begin
                    head = 0;
                    fill = 0;
                end
                default: ;
            endcase
            exp.front_value = '0;
            exp.back_value = '0;
            if (fill != 0)
            begin
                exp.front_value = ring[head];
                exp.back_value = ring[(head + fill - 1) % DEPTH];
            end
            exp.count = fill[6:0];
            exp.empty_res = (fill == 0);
            exp.full_res = (fill == DEPTH);
            exp.status = st;
            expected_q.insert(expected_q.size(), exp);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp;
            if (expected_q.size() == 0)
            begin
                $error("response with no request outstanding: %0h", got);
                failures++;
                return;
            end
            exp = expected_q[0];
            expected_q.delete(0);
            compare_field("front_value", exp.front_value, got.front_value);
            compare_field("back_value", exp.back_value, got.back_value);
            compare_field("count", WORD_W'(exp.count), WORD_W'(got.count));
            compare_field("empty_res", WORD_W'(exp.empty_res), WORD_W'(got.empty_res));
            compare_field("full_res", WORD_W'(exp.full_res), WORD_W'(got.full_res));
            compare_field("status", WORD_W'(exp.status), WORD_W'(got.status));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    dq_scoreboard sb;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 1;
    int unsigned stall_run = 0;
    logic stall_hold = 1'b0;

    double_ended_queue_top #(.CAPACITY(DEPTH)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (req_valid && !req_stall) sb.note_request(req);
            if (rsp_valid && !rsp_stall) sb.check_response(rsp);
        end
    end

    always @(negedge clk)
    begin
        if (cycle_count % 5000 < 1000)
            rsp_stall <= 1'b0;
        else
        begin
            if (stall_run == 0)
            begin
                stall_hold = ($urandom_range(0, 2) == 0);
                stall_run = stall_hold ? $urandom_range(1, 15) : $urandom_range(1, 6);
            end
            stall_run--;
            rsp_stall <= stall_hold;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("double_ended_queue_top regression: fail");
        $finish;
    end

    function automatic req_t make_req(logic [2:0] cmd, logic [WORD_W-1:0] word);
        req_t item;
        item.command = cmd;
        item.value = word;
        return item;
    endfunction

    function automatic req_t random_request(mix_t mix);
        int unsigned pick;
        logic [WORD_W-1:0] word;
        logic [2:0] cmd;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 15))
            0: word = '0;
            1: word = '1;
            default: word = $urandom;
        endcase
        case (mix)
            FILL_BIAS:  pick = (pick < 80) ? pick / 2 : 40 + (pick - 80) * 3;
            DRAIN_BIAS: pick = (pick < 80) ? 40 + pick / 2 : (pick - 80) * 2;
            default: ;
        endcase
        if (pick < 20) cmd = CMD_PUSH_FRONT;
        else if (pick < 40) cmd = CMD_PUSH_BACK;
        else if (pick < 60) cmd = CMD_POP_FRONT;
        else if (pick < 80) cmd = CMD_POP_BACK;
        else if (pick < 82) cmd = CMD_CLEAR;
        else
            case ($urandom_range(0, 2))
                0: cmd = CMD_PEEK;
                1: cmd = CMD_SPARE_6;
                default: cmd = CMD_SPARE_7;
            endcase
        return make_req(cmd, word);
    endfunction

    task automatic pace();
        int unsigned gap;
        burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 200)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic send_request(req_t item);
        @(negedge clk);
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        pace();
    endtask

    task automatic wait_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned phase_len;
        mix_t mix;
        logic pause_done;
        sb = new();
        sent = 0;
        pause_done = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(make_req(CMD_PEEK, '1));
        send_request(make_req(CMD_POP_FRONT, '0));
        send_request(make_req(CMD_POP_BACK, '1));
        send_request(make_req(CMD_PUSH_BACK, '0));
        send_request(make_req(CMD_PUSH_FRONT, '1));
        send_request(make_req(CMD_PUSH_BACK, 32'hA5A5_5A5A));
        send_request(make_req(CMD_PEEK, 32'h5A5A_A5A5));
        send_request(make_req(CMD_SPARE_6, 32'h1234_5678));
        send_request(make_req(CMD_SPARE_7, 32'h8765_4321));
        send_request(make_req(CMD_POP_BACK, '0));
        send_request(make_req(CMD_POP_FRONT, '0));
        send_request(make_req(CMD_POP_FRONT, '0));
        send_request(make_req(CMD_POP_BACK, '0));
        send_request(make_req(CMD_PUSH_FRONT, 32'h0000_0001));
        send_request(make_req(CMD_PUSH_FRONT, 32'h8000_0000));
        send_request(make_req(CMD_PUSH_BACK, 32'h7FFF_FFFF));
        send_request(make_req(CMD_CLEAR, '1));
        send_request(make_req(CMD_PEEK, '0));
        send_request(make_req(CMD_POP_FRONT, '1));
        send_request(make_req(CMD_PUSH_BACK, 32'hFFFF_0000));
        send_request(make_req(CMD_POP_BACK, '0));
        wait_drain();

        mix = FILL_BIAS;
        phase_len = 160;
        while (sent < RANDOM_REQUESTS)
        begin
            repeat (phase_len)
            begin
                send_request(random_request(mix));
                sent++;
            end
            if (!pause_done && sent >= RANDOM_REQUESTS / 2)
            begin
                wait_drain();
                pause_done = 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
                wait_drain();
            mix = mix_t'($urandom_range(0, 2));
            phase_len = $urandom_range(40, 160);
        end

        wait_drain();
        repeat (12) @(posedge clk);
        if (sb.failures == 0 && sb.expected_q.size() == 0)
            $display("double_ended_queue_top regression: pass");
        else
            $display("double_ended_queue_top regression: fail");
        $finish;
    end
endmodule
